[hdl/fsdu_pkg.sv]
package fsdu_pkg;

  localparam int DigitsDefault = 8;
  localparam int PosW          = 4;
  localparam int CfgDataW      = 4;
  localparam int PulseW        = 7;
  localparam int LetterCount   = 26;

  typedef logic [7:0] seg_t;

  typedef enum logic {
    CfgOverride = 1'b0,
    CfgStart    = 1'b1
  } cfg_idx_e;

  localparam seg_t BlankPat = 8'h00;
  localparam seg_t ResetPat = 8'hFF;

  localparam logic [PulseW-1:0] PulseBase     = 7'd50;
  localparam logic [PulseW-1:0] PulseMidExtra = 7'd45;
  localparam logic [PulseW-1:0] PulseTbExtra  = 7'd40;

  localparam logic [7:0] CaseGap   = 8'd32;
  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharDash  = 8'h2D;

  localparam seg_t NumPattern [10] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
  };

  localparam logic [7:0] GlyphKey [LetterCount] = '{
    8'h41, 8'h62, 8'h43, 8'h63, 8'h64, 8'h45, 8'h46, 8'h47, 8'h48, 8'h68,
    8'h49, 8'h4A, 8'h4C, 8'h4E, 8'h6E, 8'h4F, 8'h6F, 8'h50, 8'h71, 8'h72,
    8'h53, 8'h74, 8'h55, 8'h75, 8'h79, 8'h2D
  };

  localparam seg_t GlyphPattern [LetterCount] = '{
    8'hEE, 8'h3E, 8'h9C, 8'h1A, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h6E, 8'h2E,
    8'h60, 8'h70, 8'h1C, 8'hEC, 8'h2A, 8'hFC, 8'h3A, 8'hCE, 8'hE6, 8'h0A,
    8'hB6, 8'h1E, 8'h7C, 8'h38, 8'h76, 8'h02
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pos_ok;
    logic last_bit;
    logic slot_free;
  } sts_t;

  // {found, pattern}; scan from the end so the first table match wins
  function automatic logic [8:0] glyph_find(logic [7:0] c);
    logic [8:0] res;
    res = '0;
    for (int k = LetterCount - 1; k >= 0; k--) begin
      if (GlyphKey[k] == c) begin
        res = {1'b1, GlyphPattern[k]};
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    logic [7:0] res;
    res = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      res = c + CaseGap;
    end else if (c >= CharLoA && c <= CharLoZ) begin
      res = c - CaseGap;
    end
    return res;
  endfunction

  function automatic seg_t decode_char(logic [7:0] c);
    logic [8:0] exact;
    logic [8:0] flipped;
    logic [3:0] num;
    seg_t       pat;
    exact   = glyph_find(c);
    flipped = glyph_find(flip_case(c));
    num     = 4'(c - CharZero);
    pat     = BlankPat;
    if (c == CharHash) begin
      pat = BlankPat;
    end else if (c >= CharZero && c <= CharNine) begin
      pat = NumPattern[num];
    end else if ((c >= CharLoA && c <= CharLoZ) || (c >= CharUpA && c <= CharUpZ) ||
                 c == CharDash) begin
      if (exact[8]) begin
        pat = exact[7:0];
      end else if (flipped[8]) begin
        pat = flipped[7:0];
      end
    end
    return pat;
  endfunction

endpackage

[hdl/fsdu_in_if.sv]
interface fsdu_in_if
  import fsdu_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [7:0]      char_code;
  logic [PosW-1:0] digit_position;

  modport source (output valid, char_code, digit_position, input ready);
  modport sink   (input valid, char_code, digit_position, output ready);
endinterface

[hdl/fsdu_out_if.sv]
interface fsdu_out_if
  import fsdu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [7:0]        black_mask;
  logic [7:0]        white_mask;
  logic [7:0]        relay_mask;
  logic [PulseW-1:0] pulse_ms;
  logic              last;

  modport source (output valid, black_mask, white_mask, relay_mask, pulse_ms, last,
                  input ready);
  modport sink   (input valid, black_mask, white_mask, relay_mask, pulse_ms, last,
                  output ready);
endinterface

[hdl/fsdu_ctrl.sv]
module fsdu_ctrl
  import fsdu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == StIdle);
  assign cmd_o.load  = in_valid_i && (state_q == StIdle);
  assign cmd_o.step  = (state_q == StWalk) && sts_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      case (state_q)
        StIdle: begin
          // out-of-range positions are dropped without a walk
          if (cmd_o.load && sts_i.pos_ok) begin
            state_q <= StWalk;
          end
        end
        StWalk: begin
          if (cmd_o.step && sts_i.last_bit) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

[hdl/fsdu_dp.sv]
module fsdu_dp
  import fsdu_pkg::*;
#(
  parameter int Digits = DigitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [7:0]          in_char_i,
  input  logic [PosW-1:0]     in_pos_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [7:0]          black_o,
  output logic [7:0]          white_o,
  output logic [7:0]          relay_o,
  output logic [PulseW-1:0]   pulse_o,
  output logic                last_o
);

  localparam int IdxW = (Digits > 1) ? $clog2(Digits) : 1;

  logic                override_q;
  logic [CfgDataW-1:0] start_q;
  seg_t                shown_q [Digits];

  seg_t       pat_q, mask_q;
  logic [7:0] relay_q;
  logic [2:0] bit_q;

  logic              out_valid_q;
  logic [7:0]        black_q, white_q, relay_out_q;
  logic [PulseW-1:0] pulse_q;
  logic              last_q;

  // load-side decode
  logic [IdxW-1:0]     idx;
  seg_t                pat_new;
  seg_t                old_pat;
  logic [CfgDataW-1:0] start_eff;
  logic [4:0]          shift;
  logic [7:0]          relay_new;

  assign idx       = IdxW'(in_pos_i - 4'd1);
  assign pat_new   = decode_char(in_char_i);
  assign old_pat   = shown_q[idx];
  assign start_eff = (start_q == '0) ? CfgDataW'(1) : start_q;
  assign shift     = 5'(in_pos_i - 4'd1) + 5'(start_eff - CfgDataW'(1));
  assign relay_new = (shift < 5'd8) ? (8'h80 >> shift[2:0]) : 8'h00;

  assign sts_o.pos_ok    = (in_pos_i != '0) && (32'(in_pos_i) <= Digits);
  assign sts_o.last_bit  = (bit_q == 3'd0);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  // walk-side segment command
  logic [7:0]        onehot;
  logic [7:0]        below;
  logic              seg_on;
  logic              seg_white;
  logic [7:0]        black_d, white_d;
  logic [PulseW-1:0] pulse_d;

  assign onehot    = 8'h01 << bit_q;
  assign below     = onehot - 8'd1;
  assign seg_on    = mask_q[bit_q];
  assign seg_white = pat_q[bit_q];
  assign black_d   = seg_white ? 8'h00 : onehot;
  assign white_d   = seg_white ? onehot : 8'h00;

  always_comb begin
    if (white_d[1]) begin
      pulse_d = PulseBase + PulseMidExtra;
    end else if (black_d[7] || white_d[4]) begin
      pulse_d = PulseBase + PulseTbExtra;
    end else begin
      pulse_d = PulseBase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      override_q <= 1'b1;
      start_q    <= CfgDataW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOverride: override_q <= cfg_data_i[0];
        CfgStart:    start_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Digits; k++) begin
        shown_q[k] <= ResetPat;
      end
    end else if (cmd_i.load && sts_o.pos_ok) begin
      shown_q[idx] <= pat_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sts_o.pos_ok) begin
      pat_q   <= pat_new;
      mask_q  <= override_q ? 8'hFF : (old_pat ^ pat_new);
      relay_q <= relay_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 3'd7;
    end else if (cmd_i.load) begin
      bit_q <= 3'd7;
    end else if (cmd_i.step) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && seg_on) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && seg_on) begin
      black_q     <= black_d;
      white_q     <= white_d;
      relay_out_q <= relay_q;
      pulse_q     <= pulse_d;
      // final word when no lower segment is left to pulse
      last_q      <= ((mask_q & below) == 8'h00);
    end
  end

  assign out_valid_o = out_valid_q;
  assign black_o     = black_q;
  assign white_o     = white_q;
  assign relay_o     = relay_out_q;
  assign pulse_o     = pulse_q;
  assign last_o      = last_q;

endmodule

[hdl/flip_segment_digit_updater.sv]
// Flip-segment display digit updater.
// Input channel in_i carries one word per character: an ASCII code and a
// digit position 1..DIGITS. The character is decoded to an 8-segment pattern
// (bit 7 = top segment, bit 0 = dp) and compared with the pattern kept for
// that digit. Output channel out_o carries one pulse command per segment to
// drive, top segment first; last marks the final command of a character.
// With override mode on, all eight segments are pulsed every time.
// An accepted word is decoded in the accept cycle, then the segment walk steps
// through the eight segment bits, one segment bit per cycle while the receiver
// does not stall; the next word is taken only after the walk. The first command
// is registered once the controller is in the walk state. A position outside
// 1..DIGITS is taken and dropped with no output and no state change.
// The single output register parts the two sides: a stalled receiver holds
// the walk on the current segment, and no command is lost or repeated.
// Reset clears the stored digit patterns to all segments white, sets override
// mode on and start position 1. Configuration writes go through cfg_we_i,
// cfg_idx_i and cfg_data_i and should be made while no character is in flight.
module flip_segment_digit_updater
  import fsdu_pkg::*;
#(
  parameter int DIGITS = DigitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  fsdu_in_if.sink             in_i,
  fsdu_out_if.source          out_o
);

  cmd_t cmd;
  sts_t sts;

  fsdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fsdu_dp #(
    .Digits (DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (in_i.char_code),
    .in_pos_i    (in_i.digit_position),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .black_o     (out_o.black_mask),
    .white_o     (out_o.white_mask),
    .relay_o     (out_o.relay_mask),
    .pulse_o     (out_o.pulse_ms),
    .last_o      (out_o.last)
  );

endmodule

[hdl/fsdu_checker.sv]
module fsdu_checker
  import fsdu_pkg::*;
#(
  parameter int Digits = DigitsDefault
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic [PosW-1:0]   in_pos,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        out_black,
  input logic [7:0]        out_white,
  input logic [PulseW-1:0] out_pulse,
  input logic              out_last
);

  logic pos_in_range;
  assign pos_in_range = (in_pos != '0) && (32'(in_pos) <= Digits);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_black) && $stable(out_white) &&
                                $stable(out_pulse) && $stable(out_last))
    else $error("output word changed while stalled");

  // a valid character starts a walk that blocks further input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && pos_in_range |=> !in_ready)
    else $error("input taken again right after a valid character");

  // an out-of-range position is dropped at once
  a_drop_bad_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !pos_in_range |=> in_ready)
    else $error("out-of-range position started a walk");

  // every command drives exactly one segment to one color
  a_one_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> $onehot(out_black | out_white) && ((out_black & out_white) == 8'h00))
    else $error("command does not select exactly one segment");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind flip_segment_digit_updater fsdu_checker #(
  .Digits (DIGITS)
) u_fsdu_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_pos    (in_i.digit_position),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_black (out_o.black_mask),
  .out_white (out_o.white_mask),
  .out_pulse (out_o.pulse_ms),
  .out_last  (out_o.last)
);
